FILE: hdl/ufl_pkg.sv
package ufl_pkg;

	// Pipeline stage numbers, counted from the input register.
	localparam int ST_ERR    = 1;
	localparam int ST_PROD   = 2;
	localparam int ST_VEL    = 3;
	localparam int ST_CORDIC = 2;
	localparam int CORDIC_STEPS = 16;
	localparam int ST_MAP    = ST_CORDIC + CORDIC_STEPS;
	localparam int ST_ROT    = ST_MAP + 1;
	localparam int ST_SUM    = ST_MAP + 2;
	localparam int ST_SCALE  = ST_MAP + 3;
	localparam int ST_OUT    = ST_MAP + 4;
	localparam int NSTAGES   = ST_OUT;

	// Rotation datapath: Q30 sine and cosine in a 32-bit word.
	localparam int CW = 32;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032874;

	typedef logic [NSTAGES:1] stage_en_t;

	// Arctangent of 2^-i, 2^32 units per turn.
	function automatic logic signed [CW-1:0] atan_entry(input int unsigned idx);
		logic signed [CW-1:0] a;
		case (idx)
			0: a = 32'sd536870912;
			1: a = 32'sd316933405;
			2: a = 32'sd167458907;
			3: a = 32'sd85004756;
			4: a = 32'sd42667331;
			5: a = 32'sd21354465;
			6: a = 32'sd10679838;
			7: a = 32'sd5340245;
			8: a = 32'sd2670163;
			9: a = 32'sd1335087;
			10: a = 32'sd667544;
			11: a = 32'sd333772;
			12: a = 32'sd166886;
			13: a = 32'sd83443;
			14: a = 32'sd41722;
			15: a = 32'sd20861;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: hdl/ufl_vctrl.sv
module ufl_vctrl #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  ufl_pkg::stage_en_t           en,
	input  logic signed [DATA_WIDTH-1:0] ref_x,
	input  logic signed [DATA_WIDTH-1:0] ref_y,
	input  logic signed [DATA_WIDTH-1:0] ref_rate_x,
	input  logic signed [DATA_WIDTH-1:0] ref_rate_y,
	input  logic signed [DATA_WIDTH-1:0] meas_x,
	input  logic signed [DATA_WIDTH-1:0] meas_y,
	input  logic        [DATA_WIDTH-1:0] gain_x,
	input  logic        [DATA_WIDTH-1:0] gain_y,
	output logic signed [DATA_WIDTH+5:0] vel_x,
	output logic signed [DATA_WIDTH+5:0] vel_y
);
	import ufl_pkg::*;

	localparam int FRAC = DATA_WIDTH - 4;
	localparam int EW   = DATA_WIDTH + 1;
	localparam int PW   = 2 * DATA_WIDTH + 2;
	localparam int VW   = DATA_WIDTH + 6;
	localparam logic signed [PW-1:0] ROUND_G = PW'(1) << (FRAC - 1);

	logic signed [EW-1:0]         err_x_s1, err_y_s1;
	logic signed [DATA_WIDTH-1:0] rate_x_s1, rate_y_s1;
	logic signed [PW-1:0]         prod_x_s2, prod_y_s2;
	logic signed [DATA_WIDTH-1:0] rate_x_s2, rate_y_s2;
	logic signed [VW-1:0]         vel_x_s [ST_VEL:ST_MAP];
	logic signed [VW-1:0]         vel_y_s [ST_VEL:ST_MAP];

	always_ff @(posedge clk) begin
		if (en[ST_ERR]) begin
			err_x_s1  <= EW'(ref_x) - EW'(meas_x);
			err_y_s1  <= EW'(ref_y) - EW'(meas_y);
			rate_x_s1 <= ref_rate_x;
			rate_y_s1 <= ref_rate_y;
		end
		if (en[ST_PROD]) begin
			prod_x_s2 <= err_x_s1 * $signed({1'b0, gain_x});
			prod_y_s2 <= err_y_s1 * $signed({1'b0, gain_y});
			rate_x_s2 <= rate_x_s1;
			rate_y_s2 <= rate_y_s1;
		end
		if (en[ST_VEL]) begin
			vel_x_s[ST_VEL] <= VW'(rate_x_s2) + VW'((prod_x_s2 + ROUND_G) >>> FRAC);
			vel_y_s[ST_VEL] <= VW'(rate_y_s2) + VW'((prod_y_s2 + ROUND_G) >>> FRAC);
		end
		// The virtual control waits here while the rotation catches up.
		for (int k = ST_VEL + 1; k <= ST_MAP; k++) begin
			if (en[k]) begin
				vel_x_s[k] <= vel_x_s[k-1];
				vel_y_s[k] <= vel_y_s[k-1];
			end
		end
	end

	assign vel_x = vel_x_s[ST_MAP];
	assign vel_y = vel_y_s[ST_MAP];

endmodule

FILE: hdl/ufl_cordic.sv
module ufl_cordic #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                         clk,
	input  ufl_pkg::stage_en_t           en,
	input  logic [ANGLE_WIDTH-1:0]       heading,
	output logic signed [ufl_pkg::CW-1:0] cos_v,
	output logic signed [ufl_pkg::CW-1:0] sin_v
);
	import ufl_pkg::*;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	logic signed [CW-1:0] x_s [ST_ERR:ST_MAP-1];
	logic signed [CW-1:0] y_s [ST_ERR:ST_MAP-1];
	logic signed [CW-1:0] z_s [ST_ERR:ST_MAP-1];
	quad_t                quad_s [ST_ERR:ST_MAP-1];
	logic signed [CW-1:0] cos_s18, sin_s18;

	always_ff @(posedge clk) begin
		if (en[ST_ERR]) begin
			// Top two phase bits pick the quadrant; the rest is the angle in it.
			quad_s[ST_ERR] <= quad_t'(heading[ANGLE_WIDTH-1 -: 2]);
			z_s[ST_ERR]    <= {2'b00, heading[ANGLE_WIDTH-3:0], {(CW-ANGLE_WIDTH){1'b0}}};
			x_s[ST_ERR]    <= CORDIC_GAIN;
			y_s[ST_ERR]    <= '0;
		end
		// One rotation per stage.
		for (int k = ST_CORDIC; k < ST_MAP; k++) begin
			if (en[k]) begin
				quad_s[k] <= quad_s[k-1];
				if (!z_s[k-1][CW-1]) begin
					x_s[k] <= x_s[k-1] - (y_s[k-1] >>> (k - ST_CORDIC));
					y_s[k] <= y_s[k-1] + (x_s[k-1] >>> (k - ST_CORDIC));
					z_s[k] <= z_s[k-1] - atan_entry(k - ST_CORDIC);
				end else begin
					x_s[k] <= x_s[k-1] + (y_s[k-1] >>> (k - ST_CORDIC));
					y_s[k] <= y_s[k-1] - (x_s[k-1] >>> (k - ST_CORDIC));
					z_s[k] <= z_s[k-1] + atan_entry(k - ST_CORDIC);
				end
			end
		end
		if (en[ST_MAP]) begin
			case (quad_s[ST_MAP-1])
				QUAD_0: begin
					cos_s18 <= x_s[ST_MAP-1];
					sin_s18 <= y_s[ST_MAP-1];
				end
				QUAD_1: begin
					cos_s18 <= -y_s[ST_MAP-1];
					sin_s18 <= x_s[ST_MAP-1];
				end
				QUAD_2: begin
					cos_s18 <= -x_s[ST_MAP-1];
					sin_s18 <= -y_s[ST_MAP-1];
				end
				QUAD_3: begin
					cos_s18 <= y_s[ST_MAP-1];
					sin_s18 <= -x_s[ST_MAP-1];
				end
				default: begin
					cos_s18 <= x_s[ST_MAP-1];
					sin_s18 <= y_s[ST_MAP-1];
				end
			endcase
		end
	end

	assign cos_v = cos_s18;
	assign sin_v = sin_s18;

endmodule

FILE: hdl/ufl_invmap.sv
module ufl_invmap #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                          clk,
	input  ufl_pkg::stage_en_t            en,
	input  logic signed [DATA_WIDTH+5:0]  vel_x,
	input  logic signed [DATA_WIDTH+5:0]  vel_y,
	input  logic signed [ufl_pkg::CW-1:0] cos_v,
	input  logic signed [ufl_pkg::CW-1:0] sin_v,
	input  logic        [DATA_WIDTH-1:0]  inverse_offset,
	output logic signed [DATA_WIDTH-1:0]  linear_speed,
	output logic signed [DATA_WIDTH-1:0]  angular_speed,
	output logic                          saturated
);
	import ufl_pkg::*;

	localparam int FRAC = DATA_WIDTH - 4;
	localparam int VW   = DATA_WIDTH + 6;
	localparam int PPW  = VW + CW;
	localparam int HW   = PPW - 30;
	localparam int RW   = HW + 1;
	localparam int SPW  = RW + DATA_WIDTH + 1;
	localparam int SW   = SPW - FRAC;
	localparam logic signed [PPW-1:0] HALF_Q30 = PPW'(1) << 29;
	localparam logic signed [SPW-1:0] HALF_F   = SPW'(1) << (FRAC - 1);
	localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [PPW-1:0]        xc_s19, xs_s19, yc_s19, ys_s19;
	logic signed [RW-1:0]         lin_s20, turn_s20;
	logic signed [SPW-1:0]        scale_s21;
	logic signed [DATA_WIDTH-1:0] lin_s21;
	logic                         lin_sat_s21;
	logic signed [DATA_WIDTH-1:0] linear_speed_s22, angular_speed_s22;
	logic                         saturated_s22;
	logic signed [SW-1:0]         ang_full;

	assign ang_full = SW'((scale_s21 + HALF_F) >>> FRAC);

	always_ff @(posedge clk) begin
		if (en[ST_ROT]) begin
			xc_s19 <= vel_x * cos_v;
			xs_s19 <= vel_x * sin_v;
			yc_s19 <= vel_y * cos_v;
			ys_s19 <= vel_y * sin_v;
		end
		if (en[ST_SUM]) begin
			lin_s20  <= RW'(HW'((xc_s19 + HALF_Q30) >>> 30))
				+ RW'(HW'((ys_s19 + HALF_Q30) >>> 30));
			turn_s20 <= RW'(HW'((yc_s19 + HALF_Q30) >>> 30))
				- RW'(HW'((xs_s19 + HALF_Q30) >>> 30));
		end
		if (en[ST_SCALE]) begin
			scale_s21 <= turn_s20 * $signed({1'b0, inverse_offset});
			if (lin_s20 > RW'(D_MAX)) begin
				lin_s21     <= D_MAX;
				lin_sat_s21 <= 1'b1;
			end else if (lin_s20 < RW'(D_MIN)) begin
				lin_s21     <= D_MIN;
				lin_sat_s21 <= 1'b1;
			end else begin
				lin_s21     <= DATA_WIDTH'(lin_s20);
				lin_sat_s21 <= 1'b0;
			end
		end
		if (en[ST_OUT]) begin
			linear_speed_s22 <= lin_s21;
			if (ang_full > SW'(D_MAX)) begin
				angular_speed_s22 <= D_MAX;
				saturated_s22     <= 1'b1;
			end else if (ang_full < SW'(D_MIN)) begin
				angular_speed_s22 <= D_MIN;
				saturated_s22     <= 1'b1;
			end else begin
				angular_speed_s22 <= DATA_WIDTH'(ang_full);
				saturated_s22     <= lin_sat_s21;
			end
		end
	end

	assign linear_speed  = linear_speed_s22;
	assign angular_speed = angular_speed_s22;
	assign saturated     = saturated_s22;

endmodule

FILE: hdl/unicycle_feedback_linearization.sv
// Channel   Handshake               Payload
// item      item_valid, item_stall  ref_x, ref_y, ref_rate_x, ref_rate_y, meas_x, meas_y, heading
// result    result_valid, result_stall  linear_speed, angular_speed, saturated
// cfg       cfg_valid, cfg_ready    cfg_index, cfg_data
//
// One item enters per cycle while item_stall is low. Its result passes through the input stage,
// the sixteen-stage rotation unit, the quadrant fold, and four stages of products, rounding and
// clipping after it.
// Reset clears every stage valid bit and returns the gains and the inverse offset
// to their default values; cfg_ready is always high.
// A stalled result holds only the stages behind it that are full: empty stages keep
// taking transfers, so item_stall rises only when the whole pipeline is occupied.
module unicycle_feedback_linearization #(
	parameter int DATA_WIDTH  = 16,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic signed [DATA_WIDTH-1:0] ref_x,
	input  logic signed [DATA_WIDTH-1:0] ref_y,
	input  logic signed [DATA_WIDTH-1:0] ref_rate_x,
	input  logic signed [DATA_WIDTH-1:0] ref_rate_y,
	input  logic signed [DATA_WIDTH-1:0] meas_x,
	input  logic signed [DATA_WIDTH-1:0] meas_y,
	input  logic        [ANGLE_WIDTH-1:0] heading,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [DATA_WIDTH-1:0] linear_speed,
	output logic signed [DATA_WIDTH-1:0] angular_speed,
	output logic                         saturated,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [DATA_WIDTH-1:0]        cfg_data
);
	import ufl_pkg::*;

	localparam int FRAC = DATA_WIDTH - 4;
	localparam logic [DATA_WIDTH-1:0] GAIN_RST = DATA_WIDTH'(64'd1 << FRAC);
	localparam logic [DATA_WIDTH-1:0] INV_RST  =
		DATA_WIDTH'(((64'd10 << FRAC) + 64'd1) / 64'd3);

	typedef enum logic [1:0] {
		REG_GAIN_X     = 2'd0,
		REG_GAIN_Y     = 2'd1,
		REG_INV_OFFSET = 2'd2
	} cfg_reg_t;

	logic [DATA_WIDTH-1:0] gain_x_q, gain_y_q, inv_offset_q;
	stage_en_t             valid_s;
	stage_en_t             en;
	logic signed [DATA_WIDTH+5:0] vel_x, vel_y;
	logic signed [CW-1:0]  cos_v, sin_v;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q     <= GAIN_RST;
			gain_y_q     <= GAIN_RST;
			inv_offset_q <= INV_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN_X:     gain_x_q     <= cfg_data;
				REG_GAIN_Y:     gain_y_q     <= cfg_data;
				REG_INV_OFFSET: inv_offset_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A stage may load when some stage at or after it is empty, or the result
	// is being taken.
	always_comb begin
		for (int k = 1; k <= NSTAGES; k++) begin
			logic hole;
			hole = 1'b0;
			for (int j = k; j <= NSTAGES; j++) begin
				hole = hole | ~valid_s[j];
			end
			en[k] = hole | ~result_stall;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[1]) begin
				valid_s[1] <= item_valid;
			end
			for (int k = 2; k <= NSTAGES; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	assign item_stall   = ~en[1];
	assign result_valid = valid_s[NSTAGES];

	ufl_vctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_vctrl (
		.clk        (clk),
		.en         (en),
		.ref_x      (ref_x),
		.ref_y      (ref_y),
		.ref_rate_x (ref_rate_x),
		.ref_rate_y (ref_rate_y),
		.meas_x     (meas_x),
		.meas_y     (meas_y),
		.gain_x     (gain_x_q),
		.gain_y     (gain_y_q),
		.vel_x      (vel_x),
		.vel_y      (vel_y)
	);

	ufl_cordic #(
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_cordic (
		.clk     (clk),
		.en      (en),
		.heading (heading),
		.cos_v   (cos_v),
		.sin_v   (sin_v)
	);

	ufl_invmap #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_invmap (
		.clk            (clk),
		.en             (en),
		.vel_x          (vel_x),
		.vel_y          (vel_y),
		.cos_v          (cos_v),
		.sin_v          (sin_v),
		.inverse_offset (inv_offset_q),
		.linear_speed   (linear_speed),
		.angular_speed  (angular_speed),
		.saturated      (saturated)
	);

endmodule
